>>> hdl/ale_pkg.sv
// shared constants, request and status codes, and the memory command struct
// for the array list engine; no dependencies, compiled first

package ale_pkg;

   // list capacity and derived widths
   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // fixed field widths of the request and response channels
   localparam int TYPE_W = 3;
   localparam int POS_W  = 5;
   localparam int WORD_W = 32;
   localparam int FILL_W = 5;
   localparam int STAT_W = 2;

   // common width for comparing a position against the fill count
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   // request kinds
   typedef enum logic [TYPE_W-1:0] {
      OP_READ     = 3'd0,
      OP_WRITE    = 3'd1,
      OP_APPEND   = 3'd2,
      OP_POP      = 3'd3,
      OP_CONTAINS = 3'd4,
      OP_REMOVE   = 3'd5
   } op_type;

   // response status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_EMPTY = 2'd3
   } stat_type;

   // one cycle of commands to the entry store
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } mem_cmd_type;

endpackage

>>> hdl/array_list_engine.sv
// top level of the array list engine: request sequencer, fill count and
// response register; depends on ale_pkg and ale_store
//
// A list of up to DEPTH signed 32-bit words held in one single-port-read,
// single-port-write memory and walked by a small sequencer. The block takes
// one request at a time and gives one response per request. A read passes
// through the execute, read-wait and finish steps, as the memory read is
// registered; write, append, pop and other codes go from execute straight
// to finish. Contains compares entries in order until one matches or the
// fill count is reached. Remove scans the same way, and one that matches
// also shifts every later entry down, one a cycle. Scan and shift go one
// entry a cycle through the memory port. The next request is taken once
// the response is in the output register, even if it is not yet taken; a
// response that is still held in the output register stalls the finish
// step until it is taken.

module array_list_engine
   import ale_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [TYPE_W-1:0] req_type,
   input  logic [POS_W-1:0]  req_position,
   input  logic [WORD_W-1:0] req_word,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_read_word,
   output logic              rsp_found,
   output logic [FILL_W-1:0] rsp_fill_count,
   output logic [STAT_W-1:0] rsp_status
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_EXEC   = 6'b000010,
      ST_RWAIT  = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_SHIFT  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [TYPE_W-1:0] op_ff, op_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [WORD_W-1:0] res_word_ff, res_word_in;
   logic              res_found_ff, res_found_in;
   stat_type          res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [FILL_W-1:0] rsp_fill_ff, rsp_fill_in;
   stat_type          rsp_status_ff, rsp_status_in;

   mem_cmd_type       mem_cmd;
   logic [WORD_W-1:0] rd_data;

   logic              req_take;
   logic              pos_ok;
   logic [IDX_W-1:0]  pos_addr;
   logic              hit;
   logic [CNT_W-1:0]  shift_dst;

   ale_store u_store (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_data (rd_data)
   );

   // request handshake
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   // position check and match detection
   assign pos_ok    = (pos_ff != '0) && (CMP_W'(pos_ff) <= CMP_W'(count_ff));
   assign pos_addr  = IDX_W'(pos_ff - POS_W'(1));
   assign hit       = pend_ff && (rd_data == word_ff);
   assign shift_dst = idx_ff - CNT_W'(2);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      word_in       = word_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      res_word_in   = res_word_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_word_in   = rsp_word_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_status_in = rsp_status_ff;
      mem_cmd       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in         = req_type;
               pos_in        = req_position;
               word_in       = req_word;
               res_word_in   = '0;
               res_found_in  = 1'b0;
               res_status_in = STAT_OK;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
            case (op_ff)
               OP_READ: begin
                  if (pos_ok) begin
                     mem_cmd.rd_en   = 1'b1;
                     mem_cmd.rd_addr = pos_addr;
                     state_in        = ST_RWAIT;
                  end else begin
                     res_status_in = STAT_RANGE;
                  end
               end
               OP_WRITE: begin
                  if (pos_ok) begin
                     mem_cmd.wr_en   = 1'b1;
                     mem_cmd.wr_addr = pos_addr;
                     mem_cmd.wr_data = word_ff;
                  end else begin
                     res_status_in = STAT_RANGE;
                  end
               end
               OP_APPEND: begin
                  if (count_ff < CNT_W'(DEPTH)) begin
                     mem_cmd.wr_en   = 1'b1;
                     mem_cmd.wr_addr = count_ff[IDX_W-1:0];
                     mem_cmd.wr_data = word_ff;
                     count_in        = count_ff + CNT_W'(1);
                  end else begin
                     res_status_in = STAT_FULL;
                  end
               end
               OP_POP: begin
                  if (count_ff != '0) begin
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     res_status_in = STAT_EMPTY;
                  end
               end
               OP_CONTAINS, OP_REMOVE: begin
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  state_in = ST_SCAN;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_RWAIT: begin
            res_word_in = rd_data;
            state_in    = ST_FINISH;
         end
         // compare the entry read last cycle and, without a match, read the next one
         ST_SCAN: begin
            if (hit) begin
               res_found_in = 1'b1;
               pend_in      = 1'b0;
               if (op_ff == OP_REMOVE) begin
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (idx_ff < count_ff) begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = idx_ff[IDX_W-1:0];
               idx_in          = idx_ff + CNT_W'(1);
               pend_in         = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_FINISH;
            end
         end
         // move each later entry down one slot, read and write overlapped
         ST_SHIFT: begin
            if (pend_ff) begin
               mem_cmd.wr_en   = 1'b1;
               mem_cmd.wr_addr = shift_dst[IDX_W-1:0];
               mem_cmd.wr_data = rd_data;
            end
            if (idx_ff < count_ff) begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = idx_ff[IDX_W-1:0];
               idx_in          = idx_ff + CNT_W'(1);
               pend_in         = 1'b1;
            end else begin
               pend_in  = 1'b0;
               count_in = count_ff - CNT_W'(1);
               state_in = ST_FINISH;
            end
         end
         // hand the result to the response register once it is free
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = res_word_ff;
               rsp_found_in  = res_found_ff;
               rsp_fill_in   = FILL_W'(count_ff);
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      word_ff       <= word_in;
      idx_ff        <= idx_in;
      res_word_ff   <= res_word_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_word  = rsp_word_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_fill_count = rsp_fill_ff;
   assign rsp_status     = rsp_status_ff;

   // fill count never passes capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above capacity");

   // a new response only comes out of the finish step
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && rsp_valid_ff && !$past(rsp_valid_ff)
         |-> $past(state_ff) == ST_FINISH)
      else $error("response raised outside finish step");

   // fill count moves only in execute or shift steps
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && count_ff != $past(count_ff)
         |-> ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_SHIFT))
      else $error("fill count changed in wrong step");

   // an accepted request always goes to the execute step
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_EXEC)
      else $error("accepted request not executed");

   // a found flag never comes with an error status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_status_ff == STAT_OK)
      else $error("found flag with error status");

endmodule

>>> hdl/ale_store.sv
// entry store of the array list engine: one write and one read port,
// read data registered; depends on ale_pkg

module ale_store
   import ale_pkg::*;
(
   input  logic              clock,
   input  mem_cmd_type       cmd,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
